// ===== sv/bsa_pkg.sv =====
// Shared types and constants for the bitmap slot allocator.
// No dependencies; imported by bsa_locate and the allocator unit.
`default_nettype none

package bsa_pkg;

   localparam int MAX_SLOTS_DEF = 1024;
   localparam int WORD_BITS_DEF = 32;

   localparam int SLOT_W     = 10;
   localparam int COUNT_W    = 11;
   localparam int OP_W       = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0] BIT_COUNT_RESET = 11'd1024;

   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   localparam logic REG_BIT_COUNT = 1'b0;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SPLIT,
      ST_MODIFY
   } state_type;

   typedef struct packed {
      logic wr;
      logic full;
   } mark_cmd_type;

endpackage

`default_nettype wire

// ===== sv/bsa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; used for the slot bitmap words.
`default_nettype none

module bsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/bsa_locate.sv =====
// Per-word full marks and the finder for the lowest word with a clear bit.
// Depends on bsa_pkg for the mark update command.
`default_nettype none

module bsa_locate #(
   parameter int WORD_COUNT = 32,
   localparam int WA_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bsa_pkg::mark_cmd_type mark_cmd,
   input  logic [WA_W-1:0]       mark_word,
   output logic [WA_W-1:0]       first_word,
   output logic                  any_free
);

   import bsa_pkg::*;

   logic [WORD_COUNT-1:0] full_ff;
   logic [WORD_COUNT-1:0] full_in;

   always_comb begin
      full_in = full_ff;
      for (int j = 0; j < WORD_COUNT; j++) begin
         if (mark_cmd.wr && mark_word == WA_W'(j)) begin
            full_in[j] = mark_cmd.full;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= '0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_comb begin
      first_word = '0;
      for (int j = WORD_COUNT - 1; j >= 0; j--) begin
         if (!full_ff[j]) begin
            first_word = WA_W'(j);
         end
      end
      any_free = ~&full_ff;
   end

endmodule

`default_nettype wire

// ===== sv/bitmap_slot_allocator_unit.sv =====
// Bitmap slot allocator: request decode, read-modify-write sequencer, CSR port.
// Depends on bsa_pkg, bsa_ram and bsa_locate.
// A request passes accept, index split and RAM read, then modify and write back;
// the result is registered. A new request is taken only after the last one has
// finished; the modify step holds while the result register is not drained.
// Reset: bit_count returns to 1024; the bitmap RAM is zeroed one word a cycle,
// all WORD_COUNT words, with req_ready low meanwhile.
`default_nettype none

module bitmap_slot_allocator_unit #(
   parameter int MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF,
   parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [bsa_pkg::OP_W-1:0]         req_operation,
   input  logic [bsa_pkg::SLOT_W-1:0]       req_slot_index,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_success,
   output logic                             rsp_bit_value,
   output logic [bsa_pkg::SLOT_W-1:0]       rsp_allocated_index,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bsa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bsa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bsa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   import bsa_pkg::*;

   localparam int WORD_COUNT = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int WA_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BI_W       = $clog2(WORD_BITS);
   localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
   localparam int EXT_W      = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int BW         = EXT_W + BI_W;
   localparam int TAKEN_W    = (CNT_W + 1 > SLOT_W) ? CNT_W + 1 : SLOT_W;
   localparam int QW         = (WA_W > SLOT_W) ? WA_W : SLOT_W;
   localparam int RSH        = SLOT_W + BI_W;
   localparam int RECIP      = (1 << RSH) / WORD_BITS;
   localparam int PROD_W     = SLOT_W + RSH + 1;
   localparam int REM_W      = SLOT_W + 1;

   state_type state_ff, state_in;

   logic [COUNT_W-1:0]   bit_count_ff;
   logic [WA_W-1:0]      clr_ff;
   logic [OP_W-1:0]      op_ff;
   logic [SLOT_W-1:0]    idx_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [QW-1:0]        q_ff;
   logic [WA_W-1:0]      alloc_word_ff;
   logic                 alloc_any_ff;
   logic [WA_W-1:0]      word_ff, word_in;
   logic [BI_W-1:0]      bit_ff, bit_in;
   logic                 in_range_ff, in_range_in;
   logic [CNT_W-1:0]     base_ff;
   logic [WORD_BITS-1:0] mask_ff, mask_in;
   logic                 rsp_valid_ff;
   logic                 rsp_success_ff;
   logic                 rsp_bit_value_ff;
   logic [SLOT_W-1:0]    rsp_allocated_index_ff;

   logic                 accept;
   logic                 done;
   logic                 csr_wr;
   logic                 csr_reg;
   logic [EXT_W-1:0]     count_ext;
   logic [CNT_W-1:0]     usable_cnt;
   logic [PROD_W-1:0]    q_prod;
   logic [QW-1:0]        q_est;
   logic [REM_W-1:0]     rem;
   logic [QW-1:0]        word_q;
   logic [BW-1:0]        base_wide;
   logic [BW-1:0]        rem_cnt;
   logic                 alloc_ok;
   logic                 idx_ok;

   logic [WORD_BITS-1:0] rd_word;
   logic [WORD_BITS-1:0] free_bits;
   logic [WORD_BITS-1:0] new_word;
   logic [BI_W-1:0]      pos;
   logic                 hit;
   logic                 mod_wr;
   logic                 mod_success;
   logic                 mod_value;
   logic [TAKEN_W-1:0]   mod_taken;

   logic                 ram_we;
   logic [WA_W-1:0]      ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;
   logic                 ram_re;
   mark_cmd_type         mark_cmd;
   logic [WA_W-1:0]      first_word;
   logic                 any_free;

   // configuration port
   assign csr_reg    = csr_paddr[CSR_ADDR_W-1];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_reg)
         REG_BIT_COUNT: csr_prdata = CSR_DATA_W'(bit_count_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= BIT_COUNT_RESET;
      end else if (csr_wr && csr_reg == REG_BIT_COUNT) begin
         bit_count_ff <= csr_pwdata[COUNT_W-1:0];
      end
   end

   assign count_ext  = EXT_W'(bit_count_ff);
   assign usable_cnt = (count_ext > EXT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                       : CNT_W'(count_ext);

   // word estimate by reciprocal multiply; low by at most one
   assign q_prod = PROD_W'(req_slot_index) * PROD_W'(RECIP);
   assign q_est  = QW'(q_prod >> RSH);

   // state machine
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == WA_W'(WORD_COUNT - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      ram_re    = 1'b0;
      done      = 1'b0;
      unique case (state_ff)
         ST_CLEAR:  req_ready = 1'b0;
         ST_IDLE:   req_ready = 1'b1;
         ST_SPLIT:  ram_re    = 1'b1;
         ST_MODIFY: done      = !rsp_valid_ff || rsp_ready;
         default:   req_ready = 1'b0;
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
      end
   end

   // split the slot index into word and bit, and build the allocate mask
   always_comb begin
      rem = REM_W'(idx_ff) - REM_W'(q_ff) * REM_W'(WORD_BITS);
      if (rem >= REM_W'(WORD_BITS)) begin
         word_q = q_ff + 1'b1;
         bit_in = BI_W'(rem - REM_W'(WORD_BITS));
      end else begin
         word_q = q_ff;
         bit_in = BI_W'(rem);
      end
      idx_ok    = EXT_W'(idx_ff) < EXT_W'(cnt_ff);
      base_wide = BW'(alloc_word_ff) * BW'(WORD_BITS);
      alloc_ok  = alloc_any_ff && (base_wide < BW'(cnt_ff));
      rem_cnt   = BW'(cnt_ff) - base_wide;
      for (int j = 0; j < WORD_BITS; j++) begin
         mask_in[j] = BW'(j) < rem_cnt;
      end
      if (op_ff == OP_ALLOC) begin
         word_in     = alloc_word_ff;
         in_range_in = alloc_ok;
      end else begin
         word_in     = word_q[WA_W-1:0];
         in_range_in = idx_ok;
      end
   end

   // modify the word read back
   always_comb begin
      free_bits = ~rd_word & mask_ff;
      hit       = |free_bits;
      pos       = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (free_bits[j]) pos = BI_W'(j);
      end
      new_word    = rd_word;
      mod_wr      = 1'b0;
      mod_success = 1'b0;
      mod_value   = 1'b0;
      mod_taken   = '0;
      case (op_ff)
         OP_ALLOC: begin
            new_word    = rd_word | ({{(WORD_BITS-1){1'b0}}, 1'b1} << pos);
            mod_wr      = in_range_ff && hit;
            mod_success = in_range_ff && hit;
            if (in_range_ff && hit) begin
               mod_taken = TAKEN_W'(base_ff) + TAKEN_W'(pos);
            end
         end
         OP_FREE: begin
            new_word    = rd_word & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << bit_ff);
            mod_wr      = in_range_ff;
            mod_success = in_range_ff;
         end
         OP_QUERY: begin
            mod_success = in_range_ff;
            mod_value   = in_range_ff && rd_word[bit_ff];
         end
         default: begin
            mod_wr = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff         <= req_operation;
         idx_ff        <= req_slot_index;
         cnt_ff        <= usable_cnt;
         q_ff          <= q_est;
         alloc_word_ff <= first_word;
         alloc_any_ff  <= any_free;
      end
      if (state_ff == ST_SPLIT) begin
         word_ff     <= word_in;
         bit_ff      <= bit_in;
         in_range_ff <= in_range_in;
         base_ff     <= CNT_W'(base_wide);
         mask_ff     <= mask_in;
      end
      if (done) begin
         rsp_success_ff         <= mod_success;
         rsp_bit_value_ff       <= mod_value;
         rsp_allocated_index_ff <= mod_taken[SLOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_success         = rsp_success_ff;
   assign rsp_bit_value       = rsp_bit_value_ff;
   assign rsp_allocated_index = rsp_allocated_index_ff;

   // bitmap store and full marks
   assign ram_we    = (state_ff == ST_CLEAR) || (done && mod_wr);
   assign ram_waddr = (state_ff == ST_CLEAR) ? clr_ff : word_ff;
   assign ram_wdata = (state_ff == ST_CLEAR) ? '0 : new_word;

   assign mark_cmd.wr   = done && mod_wr;
   assign mark_cmd.full = &new_word;

   bsa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_COUNT)
   ) u_words (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (word_in),
      .rd_data (rd_word)
   );

   bsa_locate #(
      .WORD_COUNT (WORD_COUNT)
   ) u_locate (
      .clock      (clock),
      .reset      (reset),
      .mark_cmd   (mark_cmd),
      .mark_word  (word_ff),
      .first_word (first_word),
      .any_free   (any_free)
   );

`ifndef ASSERT_OFF
   a_ram_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR || state_ff == ST_MODIFY))
      else $error("bitmap RAM written outside clear or modify");

   a_rsp_after_modify: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_MODIFY))
      else $error("result raised without a modify step");

   a_taken_in_range: assert property (@(posedge clock) disable iff (reset)
      (done && op_ff == OP_ALLOC && mod_success) |-> (mod_taken < TAKEN_W'(cnt_ff)))
      else $error("allocated slot at or above the usable count");
`endif

endmodule

`default_nettype wire
